FILE: rtl/core/systick_down_counter_timer_unit_assert.svh
// Assertion macros used by the timer checker.
`ifndef SYSTICK_DOWN_COUNTER_TIMER_UNIT_ASSERT_SVH
`define SYSTICK_DOWN_COUNTER_TIMER_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define SDT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define SDT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

FILE: rtl/core/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

  localparam int CNT_W   = 24;
  localparam int TICK_W  = 16;
  localparam int DATA_W  = 32;
  localparam int WRAPS_W = 16;
  localparam int CTRL_W  = 17;
  localparam int OFF_W   = 8;
  localparam int REQ_W   = 2;

  localparam int DIV_W   = (TICK_W + 1 > CNT_W + 1) ? TICK_W + 1 : CNT_W + 1;
  localparam int CMP_W   = (TICK_W > CNT_W) ? TICK_W : CNT_W;
  localparam int STEP_W  = $clog2(TICK_W + 1);
  localparam int WRAP_CNT_W = TICK_W + 1;

  // request tdata layout, lowest bit first
  localparam int IN_OFF_LSB  = 0;
  localparam int IN_WD_LSB   = IN_OFF_LSB + OFF_W;
  localparam int IN_TICK_LSB = IN_WD_LSB + DATA_W;
  localparam int IN_RAW_W    = IN_TICK_LSB + TICK_W;
  localparam int IN_W        = ((IN_RAW_W + 7) / 8) * 8;

  // result tdata layout, lowest bit first
  localparam int OUT_RD_LSB    = 0;
  localparam int OUT_RAISE_BIT = OUT_RD_LSB + DATA_W;
  localparam int OUT_WRAPS_LSB = OUT_RAISE_BIT + 1;
  localparam int OUT_TOTAL_LSB = OUT_WRAPS_LSB + WRAPS_W;
  localparam int OUT_RAW_W     = OUT_TOTAL_LSB + DATA_W;
  localparam int OUT_W         = ((OUT_RAW_W + 7) / 8) * 8;

  localparam int PADDR_W = 3;

  localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

  localparam logic [OFF_W-1:0] OFF_CTRL  = 8'h00;
  localparam logic [OFF_W-1:0] OFF_LOAD  = 8'h04;
  localparam logic [OFF_W-1:0] OFF_VALUE = 8'h08;
  localparam logic [OFF_W-1:0] OFF_CALIB = 8'h0C;

  localparam logic [CTRL_W-1:0] CTRL_WMASK = 17'h10007;
  localparam int CTRL_ENABLE  = 0;
  localparam int CTRL_TICKINT = 1;
  localparam int CTRL_WRAP    = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/core/sdt_div.sv
`default_nettype none
module sdt_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [sdt_pkg::TICK_W-1:0]   dividend,
  input  wire  [sdt_pkg::CNT_W:0]      divisor,
  output logic                         done,
  output logic [sdt_pkg::TICK_W-1:0]   quotient,
  output logic [sdt_pkg::TICK_W-1:0]   remainder
);
  import sdt_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [TICK_W-1:0]   rem;
  logic [TICK_W-1:0]   quo;
  logic [TICK_W:0]     shifted;
  logic [DIV_W-1:0]    sh_ext;
  logic [DIV_W-1:0]    dv_ext;
  logic [DIV_W-1:0]    diff;
  logic                ge;

  always_comb begin
    shifted = {rem, quo[TICK_W-1]};
    sh_ext  = DIV_W'(shifted);
    dv_ext  = DIV_W'(divisor);
    ge      = sh_ext >= dv_ext;
    diff    = sh_ext - dv_ext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(TICK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      rem <= ge ? diff[TICK_W-1:0] : shifted[TICK_W-1:0];
      quo <= (quo << 1) | TICK_W'(ge);
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule
`default_nettype wire

FILE: rtl/core/systick_down_counter_timer_unit.sv
// Reads, writes and tick batches that do not wrap go from accept to ST_OUT, which loads the result
// into the output register once that register is free. Tick batches that wrap pass ST_DIV first,
// where a 16-step restoring divider works out the number of reloads and the remainder, one
// quotient bit per cycle; the next request is taken once the result is in the output register.
// Synchronous active-high reset clears control, reload, count, fire counter and calibration.
`default_nettype none
module systick_down_counter_timer_unit (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // reg_offset, write_data, tick_count
  input  wire  [sdt_pkg::IN_W-1:0]      s_tdata,
  // req_type
  input  wire  [sdt_pkg::REQ_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // read_data, raise_exception, wraps_fired, total_fires, zero pad
  output logic [sdt_pkg::OUT_W-1:0]     m_tdata,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [sdt_pkg::PADDR_W-1:0]   paddr,
  input  wire  [sdt_pkg::DATA_W-1:0]    pwdata,
  output logic [sdt_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import sdt_pkg::*;

  state_t                state;
  state_t                state_next;

  logic [CTRL_W-1:0]     ctrl;
  logic [CNT_W-1:0]      reload;
  logic [CNT_W-1:0]      count;
  logic [DATA_W-1:0]     fire_cnt;
  logic [DATA_W-1:0]     calib;
  logic [DATA_W-1:0]     res_rd;
  logic [WRAP_CNT_W-1:0] res_fires;

  logic                  accept;
  logic [REQ_W-1:0]      req;
  logic [OFF_W-1:0]      off;
  logic [DATA_W-1:0]     wdata;
  logic [TICK_W-1:0]     n;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      n_ext;
  logic                  no_wrap;
  logic                  tick_go;
  logic                  div_start;
  logic [CMP_W-1:0]      r_m1;
  logic [CMP_W-1:0]      count_sub;
  logic [CNT_W:0]        period;
  logic [DATA_W-1:0]     rd_mux;
  logic                  out_free;
  logic                  div_done;
  logic [TICK_W-1:0]     div_quo;
  logic [TICK_W-1:0]     div_rem;
  logic [WRAP_CNT_W-1:0] wraps;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? calib : '0;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign req      = s_tuser;
  assign off      = s_tdata[IN_OFF_LSB +: OFF_W];
  assign wdata    = s_tdata[IN_WD_LSB +: DATA_W];
  assign n        = s_tdata[IN_TICK_LSB +: TICK_W];

  always_comb begin
    count_ext = CMP_W'(count);
    n_ext     = CMP_W'(n);
    no_wrap   = count_ext >= n_ext;
    count_sub = count_ext - n_ext;
    r_m1      = n_ext - count_ext - CMP_W'(1);
    tick_go   = (req == REQ_TICK) && ctrl[CTRL_ENABLE] && (n != '0);
    div_start = accept && tick_go && !no_wrap;
    period    = {1'b0, reload} + (CNT_W + 1)'(1);
    wraps     = WRAP_CNT_W'(div_quo) + WRAP_CNT_W'(1);
    out_free  = !m_tvalid || m_tready;
  end

  always_comb begin
    unique case (off)
      OFF_CTRL:  rd_mux = DATA_W'(ctrl);
      OFF_LOAD:  rd_mux = DATA_W'(reload);
      OFF_VALUE: rd_mux = DATA_W'(count);
      OFF_CALIB: rd_mux = calib;
      default:   rd_mux = '0;
    endcase
  end

  sdt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (r_m1[TICK_W-1:0]),
    .divisor   (period),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = div_start ? ST_DIV : ST_OUT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl     <= '0;
      reload   <= '0;
      count    <= '0;
      fire_cnt <= '0;
      calib    <= '0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        calib <= pwdata;
      end
      if (accept) begin
        unique case (req)
          REQ_READ: begin
            if (off == OFF_VALUE) begin
              ctrl[CTRL_WRAP] <= 1'b0;
            end
          end
          REQ_WRITE: begin
            if (off == OFF_CTRL) begin
              ctrl <= wdata[CTRL_W-1:0] & CTRL_WMASK;
            end else if (off == OFF_LOAD) begin
              reload <= wdata[CNT_W-1:0];
            end else if (off == OFF_VALUE) begin
              count <= '0;
            end
          end
          REQ_TICK: begin
            if (tick_go && no_wrap) begin
              count <= count_sub[CNT_W-1:0];
            end
          end
          default: ;
        endcase
      end
      if (state == ST_DIV && div_done) begin
        count           <= reload - CNT_W'(div_rem);
        ctrl[CTRL_WRAP] <= 1'b1;
        if (ctrl[CTRL_TICKINT]) begin
          fire_cnt <= fire_cnt + DATA_W'(wraps);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_rd    <= (req == REQ_READ) ? rd_mux : '0;
      res_fires <= '0;
    end
    if (state == ST_DIV && div_done) begin
      res_fires <= ctrl[CTRL_TICKINT] ? wraps : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= OUT_W'({fire_cnt, WRAPS_W'(res_fires), (res_fires != '0), res_rd});
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/sdt_checker.sv
`default_nettype none
`include "systick_down_counter_timer_unit_assert.svh"
module sdt_checker (
  input wire                       clk,
  input wire                       rst,
  input wire                       s_tvalid,
  input wire                       s_tready,
  input wire                       m_tvalid,
  input wire                       m_tready,
  input wire [sdt_pkg::OUT_W-1:0]  m_tdata
);
  import sdt_pkg::*;

  `SDT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SDT_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
  `SDT_ASSERT_NOW(a_no_wraps_without_raise, m_tvalid && !m_tdata[OUT_RAISE_BIT], m_tdata[OUT_WRAPS_LSB +: WRAPS_W] == '0)

endmodule

bind systick_down_counter_timer_unit sdt_checker u_chk (.*);
`default_nettype wire

FILE: dv/systick_down_counter_timer_unit_tb.sv
`default_nettype none
module systick_down_counter_timer_unit_tb;
  import sdt_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] CALIB_ADDR = '0;
  localparam int PHASES = 4;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] wdata;
    logic [TICK_W-1:0] ticks;
  } timer_req_t;

  typedef struct packed {
    logic [DATA_W-1:0]  rd;
    logic               raise;
    logic [WRAPS_W-1:0] wraps;
    logic [DATA_W-1:0]  total;
  } timer_result_t;

  typedef struct packed {
    timer_req_t    req;
    logic          typed;
    timer_result_t want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic [REQ_W-1:0] s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  systick_down_counter_timer_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  logic [CTRL_W-1:0] ctrl_q;
  logic [CNT_W-1:0] reload_q;
  logic [CNT_W-1:0] count_q;
  logic [DATA_W-1:0] fires_q;
  logic [DATA_W-1:0] calib_q;

  timer_result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 1'b0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;

  plan_row_t plan_table [25] = '{
    {REQ_READ,   OFF_CTRL,  32'h0,        16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_LOAD,  32'h0,        16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_VALUE, 32'h0,        16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_CALIB, 32'h0,        16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   8'hFF,     32'hFFFFFFFF, 16'hFFFF,  1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'd100,   1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  OFF_LOAD,  32'hFFFFFFFF, 16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_LOAD,  32'h0,        16'd0,     1'b1, 32'hFFFFFF, 1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  OFF_CTRL,  32'hFFFFFFFF, 16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_CTRL,  32'h0,        16'd0,     1'b1, 32'h10007,  1'b0, 16'h0,    32'h0},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'd1,     1'b1, 32'h0,      1'b1, 16'h1,    32'h1},
    {REQ_READ,   OFF_VALUE, 32'h0,        16'd0,     1'b1, 32'hFFFFFF, 1'b0, 16'h0,    32'h1},
    {REQ_READ,   OFF_CTRL,  32'h0,        16'd0,     1'b1, 32'h7,      1'b0, 16'h0,    32'h1},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'hFFFF,  1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  OFF_VALUE, 32'h12345678, 16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  OFF_LOAD,  32'h0,        16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'hFFFF,  1'b1, 32'h0,      1'b1, 16'hFFFF, 32'h10000},
    {REQ_WRITE,  OFF_CTRL,  32'h1,        16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_TICK,   OFF_CTRL,  32'h0,        16'd5,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  OFF_CALIB, 32'hDEADBEEF, 16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_WRITE,  8'h10,     32'hFFFFFFFF, 16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_UNUSED, OFF_VALUE, 32'hFFFFFFFF, 16'hFFFF,  1'b0, 32'h0,      1'b0, 16'h0,    32'h0},
    {REQ_READ,   OFF_CALIB, 32'h0,        16'd0,     1'b1, 32'h0,      1'b0, 16'h0,    32'h10000},
    {REQ_WRITE,  OFF_CTRL,  32'h0,        16'd0,     1'b0, 32'h0,      1'b0, 16'h0,    32'h0}
  };

  function automatic timer_result_t advance_timer(timer_req_t q);
    timer_result_t res;
    longint unsigned span;
    longint unsigned period;
    longint unsigned nwraps;
    longint unsigned rest;
    res = '0;
    case (q.kind)
      REQ_READ: begin
        case (q.off)
          OFF_CTRL: res.rd = DATA_W'(ctrl_q);
          OFF_LOAD: res.rd = DATA_W'(reload_q);
          OFF_VALUE: begin
            res.rd = DATA_W'(count_q);
            ctrl_q[CTRL_WRAP] = 1'b0;
          end
          OFF_CALIB: res.rd = calib_q;
          default: ;
        endcase
      end
      REQ_WRITE: begin
        case (q.off)
          OFF_CTRL: ctrl_q = q.wdata[CTRL_W-1:0] & CTRL_WMASK;
          OFF_LOAD: reload_q = q.wdata[CNT_W-1:0];
          OFF_VALUE: count_q = '0;
          default: ;
        endcase
      end
      REQ_TICK: begin
        if (ctrl_q[CTRL_ENABLE] && q.ticks != '0) begin
          if (count_q >= q.ticks) begin
            count_q = count_q - q.ticks;
          end else begin
            span = longint'(q.ticks) - longint'(count_q);
            period = longint'(reload_q) + 1;
            nwraps = 1 + (span - 1) / period;
            rest = span - (nwraps - 1) * period - 1;
            count_q = CNT_W'(longint'(reload_q) - rest);
            ctrl_q[CTRL_WRAP] = 1'b1;
            if (ctrl_q[CTRL_TICKINT]) begin
              res.raise = 1'b1;
              res.wraps = nwraps[WRAPS_W-1:0];
              fires_q = fires_q + nwraps[DATA_W-1:0];
            end
          end
        end
      end
      default: ;
    endcase
    res.total = fires_q;
    return res;
  endfunction

  function automatic timer_req_t random_request();
    timer_req_t q;
    int pick;
    q.wdata = $urandom();
    q.ticks = TICK_W'($urandom());
    q.off = OFF_W'($urandom());
    pick = $urandom_range(99);
    if (pick < 25) q.kind = REQ_READ;
    else if (pick < 50) q.kind = REQ_WRITE;
    else if (pick < 95) q.kind = REQ_TICK;
    else q.kind = REQ_UNUSED;
    if ($urandom_range(99) < 88) begin
      case ($urandom_range(3))
        0: q.off = OFF_CTRL;
        1: q.off = OFF_LOAD;
        2: q.off = OFF_VALUE;
        default: q.off = OFF_CALIB;
      endcase
    end
    if (q.kind == REQ_WRITE && q.off == OFF_CTRL) begin
      if ($urandom_range(99) < 80) q.wdata[CTRL_ENABLE] = 1'b1;
      if ($urandom_range(99) < 70) q.wdata[CTRL_TICKINT] = 1'b1;
    end
    if (q.kind == REQ_WRITE && q.off == OFF_LOAD && $urandom_range(99) < 85)
      q.wdata[CNT_W-1:0] = CNT_W'($urandom_range(300));
    if (q.kind == REQ_TICK) begin
      pick = $urandom_range(99);
      if (pick < 80) q.ticks = TICK_W'($urandom_range(600));
      else if (pick < 85) q.ticks = '1;
      else if (pick < 90) q.ticks = '0;
    end
    return q;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (errors < 100) $display("mismatch %s: got %h, want %h", what, got, want);
    errors++;
  endtask

  task automatic check_result(input logic [OUT_W-1:0] data);
    timer_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unrequested result", data[OUT_RD_LSB +: DATA_W], '0);
    end else begin
      want = pending_results.pop_front();
      if (data[OUT_RD_LSB +: DATA_W] !== want.rd)
        report_mismatch("read_data", data[OUT_RD_LSB +: DATA_W], want.rd);
      if (data[OUT_RAISE_BIT] !== want.raise)
        report_mismatch("raise_exception", DATA_W'(data[OUT_RAISE_BIT]), DATA_W'(want.raise));
      if (data[OUT_WRAPS_LSB +: WRAPS_W] !== want.wraps)
        report_mismatch("wraps_fired", DATA_W'(data[OUT_WRAPS_LSB +: WRAPS_W]),
                        DATA_W'(want.wraps));
      if (data[OUT_TOTAL_LSB +: DATA_W] !== want.total)
        report_mismatch("total_fires", data[OUT_TOTAL_LSB +: DATA_W], want.total);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result(m_tdata);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 13);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(input timer_req_t q, input logic typed,
                              input timer_result_t typed_want);
    logic [IN_W-1:0] packed_req;
    timer_result_t want;
    while (!calm && $urandom_range(99) < 13) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    packed_req = '0;
    packed_req[IN_OFF_LSB +: OFF_W] = q.off;
    packed_req[IN_WD_LSB +: DATA_W] = q.wdata;
    packed_req[IN_TICK_LSB +: TICK_W] = q.ticks;
    s_tvalid <= 1'b1;
    s_tdata <= packed_req;
    s_tuser <= q.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = advance_timer(q);
    pending_results.push_back(typed ? typed_want : want);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_calib(input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CALIB_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    calib_q = value;
  endtask

  initial begin
    logic [DATA_W-1:0] calib_setting;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    ctrl_q = '0;
    reload_q = '0;
    count_q = '0;
    fires_q = '0;
    calib_q = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan_table[i])
      send_request(plan_table[i].req, plan_table[i].typed, plan_table[i].want);
    drain_results();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: calib_setting = '1;
        1: calib_setting = $urandom();
        2: calib_setting = '0;
        default: calib_setting = 32'h00000001;
      endcase
      write_calib(calib_setting);
      // phase 1 runs without any idling; phase 2 starts with a long output stall
      calm <= (phase == 1);
      if (phase == 2) hold_asked <= hold_asked + 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_request(random_request(), 1'b0, '0);
      drain_results();
    end

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
